### sv/gss_pkg.sv
// ----------------------------------------------------------------------------
// Gear shift sequencer package
// Shared codes, register indexes and bundle types of the sequencer.
// ----------------------------------------------------------------------------
package gss_pkg;

	// Width of each delay register and of the tick countdown.
	localparam int DelayWidth = 16;

	// Width of the configuration bus.
	localparam int DataWidth = 32;

	// Configuration address width: five registers at byte offsets 0 to 16.
	localparam int AddrWidth = 5;

	// Reset value of every delay register.
	localparam logic [DelayWidth-1:0] DelayReset = 16'd1000;

	// Request codes carried in the func field.
	typedef enum logic [1:0] {
		FUNC_TICK    = 2'd0,
		FUNC_UP      = 2'd1,
		FUNC_DOWN    = 2'd2,
		FUNC_NEUTRAL = 2'd3
	} func_t;

	// Register indexes, taken from paddr[4:2].
	typedef enum logic [2:0] {
		REG_CUT_DELAY     = 3'd0,
		REG_UP_DELAY      = 3'd1,
		REG_DOWN_DELAY    = 3'd2,
		REG_NEUTRAL_FIRST = 3'd3,
		REG_NEUTRAL_SECND = 3'd4
	} reg_idx_t;

	// Gear numbers that allow a neutral request.
	localparam logic [3:0] GearFirst  = 4'd1;
	localparam logic [3:0] GearSecond = 4'd2;

	// Delay settings handed to the sequencing core.
	typedef struct packed {
		logic [DelayWidth-1:0] cut_delay;
		logic [DelayWidth-1:0] up_delay;
		logic [DelayWidth-1:0] down_delay;
		logic [DelayWidth-1:0] neutral_from_first_delay;
		logic [DelayWidth-1:0] neutral_from_second_delay;
	} cfg_t;

	// One result transaction.
	typedef struct packed {
		logic cut_active;
		logic up_active;
		logic down_active;
		logic busy_out;
		logic accepted;
		logic finished;
	} result_t;

endpackage

### sv/gss_if.sv
// ----------------------------------------------------------------------------
// Gear shift sequencer channels
// Valid/ready interfaces for request transactions and result transactions.
// ----------------------------------------------------------------------------

// Request channel: func code and present gear.
interface gss_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [3:0] current_gear_in;

	modport source (output valid, output func, output current_gear_in, input ready);
	modport sink (input valid, input func, input current_gear_in, output ready);
endinterface

// Result channel: actuator lines and status flags.
interface gss_out_if;
	logic valid;
	logic ready;
	logic cut_active;
	logic up_active;
	logic down_active;
	logic busy_out;
	logic accepted;
	logic finished;

	modport source (
		output valid, output cut_active, output up_active, output down_active,
		output busy_out, output accepted, output finished, input ready
	);
	modport sink (
		input valid, input cut_active, input up_active, input down_active,
		input busy_out, input accepted, input finished, output ready
	);
endinterface

### sv/gss_core.sv
// ----------------------------------------------------------------------------
// Gear shift sequencing core
// Holds the shift phase and tick countdown and works out one result per step.
// ----------------------------------------------------------------------------
module gss_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [1:0]                    func,
	input  logic [3:0]                    current_gear_in,
	input  gss_pkg::cfg_t                 cfg,
	output gss_pkg::result_t              result
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_CUT   = 3'd1,
		PH_UP    = 3'd2,
		PH_DOWN  = 3'd3,
		PH_NUP   = 3'd4,
		PH_NDOWN = 3'd5
	} phase_t;

	phase_t                           phase_q;
	phase_t                           phase_d;
	logic [gss_pkg::DelayWidth-1:0]   remaining_q;
	logic [gss_pkg::DelayWidth-1:0]   remaining_d;
	logic                             acc;
	logic                             fin;

	// Next phase and countdown for the transaction at hand.
	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		acc         = 1'b0;
		fin         = 1'b0;
		if (func == gss_pkg::FUNC_TICK) begin
			if (phase_q != PH_IDLE) begin
				if (remaining_q > gss_pkg::DelayWidth'(1)) begin
					remaining_d = remaining_q - gss_pkg::DelayWidth'(1);
				end else if (phase_q == PH_CUT) begin
					phase_d     = PH_UP;
					remaining_d = cfg.up_delay;
				end else begin
					phase_d     = PH_IDLE;
					remaining_d = '0;
					fin         = 1'b1;
				end
			end
		end else if (phase_q == PH_IDLE) begin
			// Requests start a sequence only from idle.
			case (func)
				gss_pkg::FUNC_UP: begin
					phase_d     = PH_CUT;
					remaining_d = cfg.cut_delay;
					acc         = 1'b1;
				end
				gss_pkg::FUNC_DOWN: begin
					phase_d     = PH_DOWN;
					remaining_d = cfg.down_delay;
					acc         = 1'b1;
				end
				default: begin
					if (current_gear_in == gss_pkg::GearFirst) begin
						phase_d     = PH_NUP;
						remaining_d = cfg.neutral_from_first_delay;
						acc         = 1'b1;
					end else if (current_gear_in == gss_pkg::GearSecond) begin
						phase_d     = PH_NDOWN;
						remaining_d = cfg.neutral_from_second_delay;
						acc         = 1'b1;
					end
				end
			endcase
		end
	end

	// Result flags reflect the state after the transaction.
	always_comb begin
		result.cut_active  = (phase_d == PH_CUT);
		result.up_active   = (phase_d == PH_UP) || (phase_d == PH_NUP);
		result.down_active = (phase_d == PH_DOWN) || (phase_d == PH_NDOWN);
		result.busy_out    = (phase_d != PH_IDLE);
		result.accepted    = acc;
		result.finished    = fin;
	end

	// Phase and countdown registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
		end
	end

endmodule

### sv/gear_shift_sequencer.sv
// ----------------------------------------------------------------------------
// Gear shift sequencer
// Timed ignition-cut and solenoid sequencing for a gearbox actuator.
// ----------------------------------------------------------------------------
// Usage:
// Request transactions arrive on in_item: func selects a tick, an up-shift,
// a down-shift or a neutral request, and current_gear_in gives the present
// gear for neutral requests. Every request transaction yields exactly one
// result transaction on out_item with the three actuator lines, the busy
// flag and the accepted and finished flags.
// The user must write the delay registers through the APB-style port only
// while no transaction is in flight; the block itself does not enforce this.
// Register i lies at byte address 4*i. A request is held in the input
// register, then the phase logic feeds the result register. One
// transaction is taken every cycle, limited only by the result register.
// Reset clears the phase to idle, the countdown to zero and the delays to
// 1000 ticks. When the receiver stalls, the result register holds, the
// input register fills behind it and in_item.ready then drops until the
// result is taken.
// ----------------------------------------------------------------------------
module gear_shift_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	gss_in_if.sink                          in_item,
	gss_out_if.source                       out_item,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gss_pkg::AddrWidth-1:0]   paddr,
	input  logic [gss_pkg::DataWidth-1:0]   pwdata,
	output logic [gss_pkg::DataWidth-1:0]   prdata,
	output logic                            pready
);

	gss_pkg::cfg_t      cfg_q;
	gss_pkg::result_t   result;
	gss_pkg::result_t   result_q;
	logic               valid_s1;
	logic [1:0]         func_s1;
	logic [3:0]         gear_s1;
	logic               out_valid_q;
	logic               advance;
	logic               cfg_write;
	logic [2:0]         reg_idx;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[gss_pkg::AddrWidth-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	// Delay registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cut_delay                 <= gss_pkg::DelayReset;
			cfg_q.up_delay                  <= gss_pkg::DelayReset;
			cfg_q.down_delay                <= gss_pkg::DelayReset;
			cfg_q.neutral_from_first_delay  <= gss_pkg::DelayReset;
			cfg_q.neutral_from_second_delay <= gss_pkg::DelayReset;
		end else if (cfg_write) begin
			unique case (reg_idx)
				gss_pkg::REG_CUT_DELAY:
					cfg_q.cut_delay <= pwdata[gss_pkg::DelayWidth-1:0];
				gss_pkg::REG_UP_DELAY:
					cfg_q.up_delay <= pwdata[gss_pkg::DelayWidth-1:0];
				gss_pkg::REG_DOWN_DELAY:
					cfg_q.down_delay <= pwdata[gss_pkg::DelayWidth-1:0];
				gss_pkg::REG_NEUTRAL_FIRST:
					cfg_q.neutral_from_first_delay <= pwdata[gss_pkg::DelayWidth-1:0];
				gss_pkg::REG_NEUTRAL_SECND:
					cfg_q.neutral_from_second_delay <= pwdata[gss_pkg::DelayWidth-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back; addresses beyond the list read as zero.
	always_comb begin
		unique case (reg_idx)
			gss_pkg::REG_CUT_DELAY:
				prdata = gss_pkg::DataWidth'(cfg_q.cut_delay);
			gss_pkg::REG_UP_DELAY:
				prdata = gss_pkg::DataWidth'(cfg_q.up_delay);
			gss_pkg::REG_DOWN_DELAY:
				prdata = gss_pkg::DataWidth'(cfg_q.down_delay);
			gss_pkg::REG_NEUTRAL_FIRST:
				prdata = gss_pkg::DataWidth'(cfg_q.neutral_from_first_delay);
			gss_pkg::REG_NEUTRAL_SECND:
				prdata = gss_pkg::DataWidth'(cfg_q.neutral_from_second_delay);
			default:
				prdata = '0;
		endcase
	end

	// The input stage moves on when the result register is free or being emptied.
	assign advance       = valid_s1 && (!out_valid_q || out_item.ready);
	assign in_item.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_item.ready) begin
			valid_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_item.valid && in_item.ready) begin
			func_s1 <= in_item.func;
			gear_s1 <= in_item.current_gear_in;
		end
	end

	// Phase logic and countdown.
	gss_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.func            (func_s1),
		.current_gear_in (gear_s1),
		.cfg             (cfg_q),
		.result          (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_item.valid       = out_valid_q;
	assign out_item.cut_active  = result_q.cut_active;
	assign out_item.up_active   = result_q.up_active;
	assign out_item.down_active = result_q.down_active;
	assign out_item.busy_out    = result_q.busy_out;
	assign out_item.accepted    = result_q.accepted;
	assign out_item.finished    = result_q.finished;

endmodule
